FILE: rtl/core/dqld_pkg.sv
// Shared types, codes and character helpers for the DNS question name decoder.
`default_nettype none

package dqld_pkg;

  localparam logic [5:0] MAX_LABEL   = 6'd63;
  localparam logic [7:0] CHAR_DOT    = 8'h2E;
  localparam logic [7:0] CHAR_HYPHEN = 8'h2D;
  localparam logic [3:0] OPC_QUERY   = 4'd0;

  typedef enum logic [2:0] {
    ST_PARSING     = 3'd0,
    ST_DONE_NEW    = 3'd1,
    ST_DONE_REPEAT = 3'd2,
    ST_ERROR       = 3'd3,
    ST_SKIPPED     = 3'd4,
    ST_IDLE        = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_LEN   = 3'b010,
    PH_LABEL = 3'b100
  } phase_t;

  typedef struct packed {
    logic [7:0] name_byte;
    logic       first_byte;
    logic       last_in_packet;
    logic [3:0] header_opcode;
    logic       header_response;
  } item_t;

  typedef struct packed {
    logic [7:0] text_char;
    logic       char_valid;
    status_t    status;
    logic [8:0] name_length;
  } result_t;

  function automatic logic legal_char(input logic [7:0] c);
    logic lower, upper, digit;
    lower = (c >= 8'h61) && (c <= 8'h7A);
    upper = (c >= 8'h41) && (c <= 8'h5A);
    digit = (c >= 8'h30) && (c <= 8'h39);
    return lower || upper || digit || (c == CHAR_HYPHEN);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/dqld_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dqld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/core/dqld_step.sv
// Per-item parse step: phase update, character emission and repeat tracking.
`default_nettype none

module dqld_step
  import dqld_pkg::*;
#(
  parameter int MAX_NAME_CHARS = 255,
  parameter int CW = $clog2(MAX_NAME_CHARS + 1)
) (
  input  wire item_t            item,
  input  wire phase_t           phase,
  input  wire logic [5:0]       label_rem,
  input  wire logic [CW-1:0]    chars_used,
  input  wire logic             mismatch,
  input  wire logic             store_sel,
  input  wire logic [CW-1:0]    stored_len,
  input  wire logic [7:0]       cur_char,
  output phase_t                phase_out,
  output logic      [5:0]       label_rem_out,
  output logic      [CW-1:0]    chars_used_out,
  output logic                  mismatch_out,
  output logic                  store_sel_out,
  output logic      [CW-1:0]    stored_len_out,
  output logic                  wr_en,
  output logic      [CW-1:0]    wr_addr,
  output logic      [7:0]       wr_char,
  output result_t               res
);

  localparam int SW = CW + 2;

  phase_t        phase_w;
  logic [CW-1:0] used_w;
  logic          mis_w;
  logic          skip;
  logic [SW-1:0] pending_sum;
  logic [5:0]    rem_dec;

  assign skip    = item.first_byte && (item.header_opcode != OPC_QUERY) && !item.header_response;
  assign used_w  = item.first_byte ? '0 : chars_used;
  assign mis_w   = item.first_byte ? 1'b0 : mismatch;
  assign phase_w = item.first_byte ? PH_LEN : phase;
  assign rem_dec = label_rem - 6'd1;
  // characters so far, the separating dot, then the whole label
  assign pending_sum = SW'(used_w) + SW'(used_w != '0) + SW'(item.name_byte);

  always_comb begin
    phase_out      = phase;
    label_rem_out  = item.first_byte ? 6'd0 : label_rem;
    chars_used_out = used_w;
    mismatch_out   = mis_w;
    store_sel_out  = store_sel;
    stored_len_out = stored_len;
    wr_en          = 1'b0;
    wr_addr        = used_w;
    wr_char        = item.name_byte;
    res            = '0;
    res.status     = ST_PARSING;

    if (skip) begin
      phase_out  = PH_IDLE;
      res.status = ST_SKIPPED;
    end else begin
      unique case (phase_w)
        PH_LEN: begin
          if (item.name_byte == 8'd0) begin
            res.name_length = 9'(used_w);
            if (!mis_w && (used_w == stored_len)) begin
              res.status = ST_DONE_REPEAT;
            end else begin
              res.status     = ST_DONE_NEW;
              store_sel_out  = ~store_sel;
              stored_len_out = used_w;
            end
            phase_out = PH_IDLE;
          end else if ((item.name_byte > {2'b00, MAX_LABEL}) || item.last_in_packet ||
                       (pending_sum > SW'(MAX_NAME_CHARS))) begin
            res.status = ST_ERROR;
            phase_out  = PH_IDLE;
          end else begin
            if (used_w != '0) begin
              wr_en          = 1'b1;
              wr_char        = CHAR_DOT;
              res.text_char  = CHAR_DOT;
              res.char_valid = 1'b1;
              chars_used_out = used_w + CW'(1);
              mismatch_out   = mis_w || (used_w >= stored_len) || (cur_char != CHAR_DOT);
            end
            label_rem_out = item.name_byte[5:0];
            phase_out     = PH_LABEL;
          end
        end
        PH_LABEL: begin
          if (!legal_char(item.name_byte) || item.last_in_packet) begin
            res.status = ST_ERROR;
            phase_out  = PH_IDLE;
          end else begin
            wr_en          = 1'b1;
            res.text_char  = item.name_byte;
            res.char_valid = 1'b1;
            chars_used_out = used_w + CW'(1);
            mismatch_out   = mis_w || (used_w >= stored_len) || (cur_char != item.name_byte);
            label_rem_out  = rem_dec;
            phase_out      = (rem_dec == 6'd0) ? PH_LEN : PH_LABEL;
          end
        end
        default: begin
          phase_out  = PH_IDLE;
          res.status = ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/dns_qname_label_decoder.sv
// Top level of the DNS question name decoder: registers, name stores and output stage.
`default_nettype none

// Takes one question name byte per item and returns exactly one result item per
// input item, in the cycle after acceptance; a new item can be taken every cycle
// while out_tready stays high. A result waiting for out_tready holds in_tready
// low until it is taken. Labels come out as dotted
// text with repeat detection against the last stored name. The two name stores
// are RAMs with registered read: each cycle the store is read at the position
// the next character will take, so the compare data is ready when that item
// arrives. The stores need no clearing after reset; only positions below the
// stored length are ever compared.
module dns_qname_label_decoder
  import dqld_pkg::*;
#(
  parameter int MAX_NAME_CHARS = 255
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] name_byte
  input  wire logic [5:0]  in_tuser,   // [0] first_byte, [4:1] header_opcode, [5] header_response
  input  wire logic        in_tlast,   // last_in_packet
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [23:0] out_tdata,  // [7:0] text_char, [10:8] status, [19:11] name_length
  output logic      [0:0]  out_tuser   // [0] char_valid
);

  localparam int CW    = $clog2(MAX_NAME_CHARS + 1);
  localparam int DEPTH = MAX_NAME_CHARS + 1;

  item_t         item;
  logic          accept;
  phase_t        phase_r, phase_nxt, step_phase;
  logic [5:0]    rem_r, rem_nxt, step_rem;
  logic [CW-1:0] used_r, used_nxt, step_used;
  logic          mis_r, mis_nxt, step_mis;
  logic          sel_r, sel_nxt, step_sel;
  logic [CW-1:0] slen_r, slen_nxt, step_slen;
  logic          wr_en;
  logic [CW-1:0] wr_addr;
  logic [7:0]    wr_char;
  logic [CW-1:0] rd_addr;
  logic [7:0]    rd_a, rd_b;
  result_t       step_res;
  result_t       res_r;
  logic          out_valid_r, out_valid_nxt;

  assign item.name_byte       = in_tdata;
  assign item.first_byte      = in_tuser[0];
  assign item.last_in_packet  = in_tlast;
  assign item.header_opcode   = in_tuser[4:1];
  assign item.header_response = in_tuser[5];

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  dqld_step #(
    .MAX_NAME_CHARS(MAX_NAME_CHARS),
    .CW(CW)
  ) u_step (
    .item          (item),
    .phase         (phase_r),
    .label_rem     (rem_r),
    .chars_used    (used_r),
    .mismatch      (mis_r),
    .store_sel     (sel_r),
    .stored_len    (slen_r),
    .cur_char      (sel_r ? rd_b : rd_a),
    .phase_out     (step_phase),
    .label_rem_out (step_rem),
    .chars_used_out(step_used),
    .mismatch_out  (step_mis),
    .store_sel_out (step_sel),
    .stored_len_out(step_slen),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_char       (wr_char),
    .res           (step_res)
  );

  assign phase_nxt     = accept ? step_phase : phase_r;
  assign rem_nxt       = accept ? step_rem   : rem_r;
  assign used_nxt      = accept ? step_used  : used_r;
  assign mis_nxt       = accept ? step_mis   : mis_r;
  assign sel_nxt       = accept ? step_sel   : sel_r;
  assign slen_nxt      = accept ? step_slen  : slen_r;
  assign out_valid_nxt = accept || (out_valid_r && !out_tready);

  // fetch the stored character at the position the next item will fill
  assign rd_addr = rst_n ? used_nxt : '0;

  // new characters go to the store that is not the current one
  dqld_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store_a (
    .clk  (clk),
    .we   (accept && wr_en && sel_r),
    .waddr(wr_addr),
    .wdata(wr_char),
    .raddr(rd_addr),
    .rdata(rd_a)
  );

  dqld_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store_b (
    .clk  (clk),
    .we   (accept && wr_en && !sel_r),
    .waddr(wr_addr),
    .wdata(wr_char),
    .raddr(rd_addr),
    .rdata(rd_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      rem_r       <= '0;
      used_r      <= '0;
      mis_r       <= 1'b0;
      sel_r       <= 1'b0;
      slen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      rem_r       <= rem_nxt;
      used_r      <= used_nxt;
      mis_r       <= mis_nxt;
      sel_r       <= sel_nxt;
      slen_r      <= slen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= step_res;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {4'b0000, res_r.name_length, res_r.status, res_r.text_char};
  assign out_tuser[0] = res_r.char_valid;

endmodule

`default_nettype wire

FILE: rtl/core/dqld_checker.sv
// Port-level checks for the DNS question name decoder, bound to the top level.
`default_nettype none

module dqld_checker
  import dqld_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata,
  input wire logic [0:0]  out_tuser
);

  logic [2:0] st;
  assign st = out_tdata[10:8];

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("result item changed while stalled");

  // every accepted item yields a result on the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> out_tvalid)
    else $error("accepted item produced no result");

  // a character is only emitted while a name is being parsed
  a_char_parsing: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (st == ST_PARSING))
    else $error("character emitted with a final status");

  // name length is zero unless a name has just finished
  a_len_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (st != ST_DONE_NEW) && (st != ST_DONE_REPEAT)) |-> (out_tdata[19:11] == 9'd0))
    else $error("name length reported without a finished name");

  // output register is empty straight after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind dns_qname_label_decoder dqld_checker u_dqld_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);

`default_nettype wire

FILE: tb/dns_qname_label_decoder_test.sv
// Self-checking stream testbench for the DNS question name decoder.
`timescale 1ns / 100ps

module dns_qname_label_decoder_test;
  import dqld_pkg::*;

  localparam int         NAME_MAX     = 255;
  localparam int         TOTAL_ITEMS  = 450;
  localparam int         CALM_TAIL    = 80;
  localparam int         CYCLE_LIMIT  = 100000;

  typedef enum int {
    F_NONE,
    F_BAD_CHAR,
    F_LONG_LEN,
    F_EARLY_END,
    F_CUT,
    F_TRAILING
  } fault_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;  // [7:0] name_byte
  logic [5:0]  in_tuser   = '0;  // [0] first_byte, [4:1] header_opcode, [5] header_response
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;        // [7:0] text_char, [10:8] status, [19:11] name_length
  logic [0:0]  out_tuser;        // [0] char_valid

  dns_qname_label_decoder #(
    .MAX_NAME_CHARS(NAME_MAX)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  item_t      pending[$];
  result_t    expected_q[$];
  int         mismatches = 0;
  int         cycle_cnt  = 0;
  int         in_gap     = 0;
  int         out_gap    = 0;
  logic [7:0] name_q[$];

  // decoder state as the block should hold it
  phase_t     ph       = PH_IDLE;
  logic [5:0] lab_left = '0;
  logic [8:0] n_chars  = '0;
  logic       differs  = 1'b0;
  logic       sel      = 1'b0;
  logic [8:0] kept_len = '0;
  logic [7:0] name_a[256];
  logic [7:0] name_b[256];

  // write into the spare store while comparing against the live one
  function automatic void append_char(input logic [7:0] c);
    if (sel) begin
      name_a[n_chars] = c;
      if (n_chars >= kept_len || name_b[n_chars] != c) differs = 1'b1;
    end else begin
      name_b[n_chars] = c;
      if (n_chars >= kept_len || name_a[n_chars] != c) differs = 1'b1;
    end
    n_chars = n_chars + 9'd1;
  endfunction

  function automatic result_t decode_byte(input item_t it);
    result_t    r;
    int         pend;
    logic [7:0] c;
    logic       host_ok;
    r = '0;
    r.status = ST_PARSING;
    c = it.name_byte;
    if (it.first_byte) begin
      n_chars  = '0;
      differs  = 1'b0;
      lab_left = '0;
      if (it.header_opcode != OPC_QUERY && !it.header_response) begin
        ph = PH_IDLE;
        r.status = ST_SKIPPED;
        return r;
      end
      ph = PH_LEN;
    end
    case (ph)
      PH_LEN: begin
        if (c == 8'd0) begin
          r.name_length = n_chars;
          if (!differs && n_chars == kept_len) begin
            r.status = ST_DONE_REPEAT;
          end else begin
            r.status = ST_DONE_NEW;
            sel      = ~sel;
            kept_len = n_chars;
          end
          ph = PH_IDLE;
        end else begin
          pend = int'(n_chars) + ((n_chars != 0) ? 1 : 0);
          if (c > MAX_LABEL || it.last_in_packet || pend + int'(c) > NAME_MAX) begin
            r.status = ST_ERROR;
            ph = PH_IDLE;
          end else begin
            if (n_chars != 0) begin
              append_char(CHAR_DOT);
              r.text_char  = CHAR_DOT;
              r.char_valid = 1'b1;
            end
            lab_left = c[5:0];
            ph = PH_LABEL;
          end
        end
      end
      PH_LABEL: begin
        host_ok = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
                  (c >= "0" && c <= "9") || c == CHAR_HYPHEN;
        if (!host_ok || it.last_in_packet) begin
          r.status = ST_ERROR;
          ph = PH_IDLE;
        end else begin
          append_char(c);
          r.text_char  = c;
          r.char_valid = 1'b1;
          lab_left = lab_left - 6'd1;
          if (lab_left == 0) ph = PH_LEN;
        end
      end
      default: begin
        ph = PH_IDLE;
        r.status = ST_IDLE;
      end
    endcase
    return r;
  endfunction

  function automatic void flag_mismatch(input string what, input int want_v, input int got_v);
    if (mismatches < 10)
      $display("mismatch on %s: expected %0d, got %0d", what, want_v, got_v);
    mismatches++;
  endfunction

  // ---- stimulus helpers ----

  function automatic void push_byte(input logic [7:0] b, input logic first, input logic last,
                                    input logic [3:0] opc, input logic resp);
    item_t it;
    it.name_byte       = b;
    it.first_byte      = first;
    it.last_in_packet  = last;
    it.header_opcode   = opc;
    it.header_response = resp;
    pending.push_back(it);
  endfunction

  // header fields are don't-care away from the first byte, so scramble them
  function automatic void push_body(input logic [7:0] b, input logic last);
    push_byte(b, 1'b0, last, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
  endfunction

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r < 62) return 8'("0" + r - 52);
    return CHAR_HYPHEN;
  endfunction

  function automatic void add_label(input int len);
    name_q.push_back(8'(len));
    repeat (len) name_q.push_back(pick_char());
  endfunction

  function automatic void fresh_name();
    name_q.delete();
    repeat ($urandom_range(0, 4)) begin
      if ($urandom_range(0, 19) == 0) add_label($urandom_range(20, 63));
      else add_label($urandom_range(1, 6));
    end
  endfunction

  // random index of a length byte or of a label character in name_q, -1 if none
  function automatic int pick_slot(input bit on_length);
    int slots[$];
    int i;
    i = 0;
    while (i < name_q.size()) begin
      if (on_length) slots.push_back(i);
      else for (int k = 1; k <= name_q[i]; k++) slots.push_back(i + k);
      i += int'(name_q[i]) + 1;
    end
    if (slots.size() == 0) return -1;
    return slots[$urandom_range(0, slots.size() - 1)];
  endfunction

  // sends name_q plus terminator as one packet, damaged as asked; returns items queued
  function automatic int send_name(input fault_t fault, input logic [3:0] opc,
                                   input logic resp);
    logic [7:0] pkt[$];
    int         slot;
    int         stop;
    int         extra;
    logic       last;
    pkt = name_q;
    pkt.push_back(8'd0);
    stop  = pkt.size() - 1;
    extra = 0;
    case (fault)
      F_BAD_CHAR: begin
        slot = pick_slot(1'b0);
        if (slot >= 0) pkt[slot] = 8'($urandom_range(0, 255));
      end
      F_LONG_LEN: begin
        slot = pick_slot(1'b1);
        if (slot >= 0) pkt[slot] = 8'($urandom_range(64, 255));
      end
      F_EARLY_END, F_CUT: stop = $urandom_range(0, pkt.size() - 1);
      default: ;
    endcase
    for (int n = 0; n <= stop; n++) begin
      last = (n == stop) && fault != F_CUT && fault != F_TRAILING;
      if (n == 0) push_byte(pkt[0], 1'b1, last, opc, resp);
      else push_body(pkt[n], last);
    end
    if (fault == F_TRAILING) begin
      extra = $urandom_range(1, 3);
      for (int n = 0; n < extra; n++) push_body(8'($urandom_range(0, 255)), n == extra - 1);
    end
    return stop + 1 + extra;
  endfunction

  // ---- stimulus and end of run ----

  initial begin : stim_p
    int         pick;
    int         slot;
    int         start;
    int         i;
    logic       resp;
    logic [3:0] opc;
    fault_t     fault;

    // stray byte outside any packet
    push_byte(8'hFF, 1'b0, 1'b0, OPC_QUERY, 1'b0);
    // empty name at reset matches the empty stored name
    push_byte(8'd0, 1'b1, 1'b1, OPC_QUERY, 1'b0);
    // "a", then the same again
    repeat (2) begin
      push_byte(8'd1, 1'b1, 1'b0, OPC_QUERY, 1'b0);
      push_body("a", 1'b0);
      push_body(8'd0, 1'b1);
    end
    // other opcode without response flag: skipped, rest ignored
    push_byte(8'd1, 1'b1, 1'b0, 4'd15, 1'b0);
    push_body("a", 1'b1);
    // other opcode as a response is parsed: "zZ.-"
    push_byte(8'd2, 1'b1, 1'b0, 4'd15, 1'b1);
    push_body("z", 1'b0);
    push_body("Z", 1'b0);
    push_body(8'd1, 1'b0);
    push_body(CHAR_HYPHEN, 1'b0);
    push_body(8'd0, 1'b1);
    // label length too big
    push_byte(8'd64, 1'b1, 1'b1, OPC_QUERY, 1'b0);
    // illegal character
    push_byte(8'd1, 1'b1, 1'b0, OPC_QUERY, 1'b0);
    push_body(8'h80, 1'b1);
    // packet ends on a label character
    push_byte(8'd2, 1'b1, 1'b0, OPC_QUERY, 1'b0);
    push_body("9", 1'b0);
    push_body("0", 1'b1);
    // packet ends on a non-zero length byte
    push_byte(8'd1, 1'b1, 1'b0, OPC_QUERY, 1'b0);
    push_body("A", 1'b0);
    push_body(8'd1, 1'b1);
    // new packet abandons a name in progress
    push_byte(8'd2, 1'b1, 1'b0, OPC_QUERY, 1'b0);
    push_body("0", 1'b0);
    push_byte(8'd1, 1'b1, 1'b0, OPC_QUERY, 1'b0);
    push_body("9", 1'b0);
    push_body(8'd0, 1'b1);
    // empty name after a non-empty one is new
    push_byte(8'd0, 1'b1, 1'b1, OPC_QUERY, 1'b0);

    // four full labels fill the name exactly, one label more overflows
    name_q.delete();
    repeat (4) add_label(63);
    add_label(1);
    void'(send_name(F_NONE, OPC_QUERY, 1'b1));

    fresh_name();
    while (pending.size() < TOTAL_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        push_body(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else if (pick < 12) begin
        fresh_name();
        void'(send_name(F_NONE, 4'($urandom_range(1, 15)), 1'b0));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
          // same name again
        end else if (pick < 45) begin
          slot = pick_slot(1'b0);
          if (slot >= 0) name_q[slot] = pick_char();
        end else if (pick < 52) begin
          if (name_q.size() < 200) add_label($urandom_range(1, 6));
        end else if (pick < 58) begin
          i = 0;
          start = 0;
          while (i < name_q.size()) begin
            start = i;
            i += int'(name_q[i]) + 1;
          end
          while (name_q.size() > start) void'(name_q.pop_back());
        end else begin
          fresh_name();
        end
        resp  = 1'($urandom_range(0, 1));
        opc   = resp ? 4'($urandom_range(0, 15)) : OPC_QUERY;
        fault = ($urandom_range(0, 3) == 0) ? fault_t'($urandom_range(1, 5)) : F_NONE;
        void'(send_name(fault, opc, resp));
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (pending.size() != 0 || in_tvalid || expected_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---- driver ----

  always @(posedge clk) begin : drive_p
    item_t taken;
    item_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        taken.name_byte       = in_tdata;
        taken.first_byte      = in_tuser[0];
        taken.header_opcode   = in_tuser[4:1];
        taken.header_response = in_tuser[5];
        taken.last_in_packet  = in_tlast;
        expected_q.push_back(decode_byte(taken));
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (pending.size() == 0) begin
          in_tvalid <= 1'b0;
        end else if (pending.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
          in_gap = $urandom_range(0, 5);
          in_tvalid <= 1'b0;
        end else begin
          nxt = pending.pop_front();
          in_tdata  <= nxt.name_byte;
          in_tuser  <= {nxt.header_response, nxt.header_opcode, nxt.first_byte};
          in_tlast  <= nxt.last_in_packet;
          in_tvalid <= 1'b1;
        end
      end
    end
  end

  // ---- monitor ----

  always @(posedge clk) begin : watch_p
    result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          flag_mismatch("result with none pending", 0, 1);
        end else begin
          want = expected_q.pop_front();
          if (out_tdata[7:0] !== want.text_char)
            flag_mismatch("text_char", want.text_char, out_tdata[7:0]);
          if (out_tuser[0] !== want.char_valid)
            flag_mismatch("char_valid", want.char_valid, out_tuser[0]);
          if (out_tdata[10:8] !== want.status)
            flag_mismatch("status", want.status, out_tdata[10:8]);
          if (out_tdata[19:11] !== want.name_length)
            flag_mismatch("name_length", want.name_length, out_tdata[19:11]);
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else if (pending.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(0, 5);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

endmodule
